// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/f23as_pkg.sv
// Package with widths and types of the 23-bit float adder
`timescale 1ns / 1ps
package f23as_pkg;
    localparam int ExpW = 6;
    localparam int ManW = 16;
    localparam int SumW = 18;
    localparam int ShW  = 5;
    localparam logic [ShW-1:0] ShiftZero = 5'd31;

    typedef struct packed {
        logic            sign;
        logic [ExpW-1:0] exponent;
        logic [ManW-1:0] mantissa;
    } f23_t;

    typedef struct packed {
        logic            sign;
        logic [ExpW-1:0] exponent;
        logic [SumW-1:0] sum;
    } sum_t;

    // Left shift from priority search over sum bits 17..2
    function automatic logic [ShW-1:0] lead_shift(input logic [SumW-1:0] s);
        logic [ShW-1:0] r;
        r = ShiftZero;
        for (int k = 2; k < SumW; k++)
        begin
            if (s[k])
            begin
                r = ShW'(SumW - 1 - k);
            end
        end
        return r;
    endfunction
endpackage

// File: rtl/core/f23as_norm.sv
// Normalization stage: leading-one search, exponent adjust and shift
`timescale 1ns / 1ps
module f23as_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  f23as_pkg::sum_t in_data,
    output logic           out_valid,
    output f23as_pkg::f23_t out_data
);
    logic                          v1_reg;
    f23as_pkg::sum_t               s1_reg;
    logic [f23as_pkg::ShW-1:0]     sh1_reg;
    logic [f23as_pkg::ShW-1:0]     sh1_next;
    logic                          v2_reg;
    f23as_pkg::f23_t               r2_reg;
    f23as_pkg::f23_t               r2_next;
    logic [f23as_pkg::SumW-1:0]    shifted;
    logic [f23as_pkg::ExpW:0]      e_adj;

    assign sh1_next = f23as_pkg::lead_shift(in_data.sum);

    always_comb
    begin
        shifted = (s1_reg.sum >> 1) << sh1_reg;
        e_adj = {1'b0, s1_reg.exponent} - {2'b0, sh1_reg} + 7'd1;
        r2_next.sign = s1_reg.sign;
        r2_next.mantissa = shifted[f23as_pkg::ManW-1:0];
        if ({1'b0, s1_reg.exponent} < {2'b0, sh1_reg})
        begin
            r2_next.exponent = '0;
        end
        else
        begin
            r2_next.exponent = e_adj[f23as_pkg::ExpW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= in_data;
            sh1_reg <= sh1_next;
            r2_reg  <= r2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = r2_reg;
endmodule

// File: rtl/core/float23_add_sub_top.sv
// Top level of the pipelined 23-bit float adder/subtractor
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: a_sign, a_exponent, a_mantissa, b_sign, b_exponent,
//         |     |        b_mantissa, operation, 1 zero pad bit
// m_axis  | out | tdata: res_sign, res_exponent, res_mantissa, 1 zero pad bit
//
// Five register stages: swap, align, add, leading-one search, shift/exponent.
// One transfer per cycle is taken and delivered while the output is not stalled.
// The whole pipe advances together when the output slot is free or empty;
// a stall holds every stage. rst_n clears only valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module float23_add_sub_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // a_sign, a_exponent, a_mantissa, b_sign,
                                       // b_exponent, b_mantissa, operation, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // res_sign, res_exponent, res_mantissa, pad
);
    localparam int EW = f23as_pkg::ExpW;
    localparam int MW = f23as_pkg::ManW;

    logic en;
    logic out_valid;
    f23as_pkg::f23_t out_data;

    // stage 0 inputs
    f23as_pkg::f23_t in_a, in_b;
    assign in_a  = '{s_axis_tdata[0], s_axis_tdata[6:1], s_axis_tdata[22:7]};
    assign in_b  = '{s_axis_tdata[23] ^ s_axis_tdata[46], s_axis_tdata[29:24],
                     s_axis_tdata[45:30]};

    // stage 1: ordered operands
    logic            v1_reg;
    f23as_pkg::f23_t a1_reg, b1_reg;
    f23as_pkg::f23_t a1_next, b1_next;
    always_comb
    begin
        if ({in_a.exponent, in_a.mantissa} < {in_b.exponent, in_b.mantissa})
        begin
            a1_next = in_b;
            b1_next = in_a;
        end
        else
        begin
            a1_next = in_a;
            b1_next = in_b;
        end
    end

    // stage 2: aligned significands
    logic          v2_reg;
    logic          s2_reg, sub2_reg;
    logic [EW-1:0] e2_reg;
    logic [MW:0]   ma2_reg, mb2_reg;
    logic [MW:0]   ma2_next, mb2_next, mbx;
    logic [EW-1:0] diff;
    always_comb
    begin
        ma2_next = {a1_reg.exponent != '0, a1_reg.mantissa};
        mbx = {b1_reg.exponent != '0, b1_reg.mantissa};
        diff = a1_reg.exponent - b1_reg.exponent;
        mb2_next = (diff[EW-1:4] != '0) ? '0 : (mbx >> diff[3:0]);
    end

    // stage 3: sum
    logic            v3_reg;
    f23as_pkg::sum_t r3_reg, r3_next;
    always_comb
    begin
        r3_next.sign = s2_reg;
        r3_next.exponent = e2_reg;
        if (sub2_reg)
        begin
            r3_next.sum = {1'b0, ma2_reg} - {1'b0, mb2_reg};
        end
        else
        begin
            r3_next.sum = {1'b0, ma2_reg} + {1'b0, mb2_reg};
        end
    end

    assign en = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
            s2_reg   <= a1_reg.sign;
            sub2_reg <= a1_reg.sign ^ b1_reg.sign;
            e2_reg   <= a1_reg.exponent;
            ma2_reg  <= ma2_next;
            mb2_reg  <= mb2_next;
            r3_reg   <= r3_next;
        end
    end

    f23as_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_data   (r3_reg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {1'b0, out_data.mantissa, out_data.exponent, out_data.sign};

    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
    `ASSERT_CLK(a_pad, clk, rst_n, !m_axis_tvalid || m_axis_tdata[23] == 1'b0,
        "pad bit set on output")
    `ASSERT_NEXT(a_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready || m_axis_tvalid,
        "pipe not ready while output empty")
endmodule

// File: bench/float23_add_sub_top_tb.sv
// Self-checking testbench for the pipelined 23-bit float adder/subtractor
`timescale 1ns / 1ps
module float23_add_sub_top_tb;
    localparam int EW = f23as_pkg::ExpW;
    localparam int MW = f23as_pkg::ManW;

    typedef struct packed {
        logic            b_sub;
        logic [MW-1:0]   b_man;
        logic [EW-1:0]   b_exp;
        logic            b_sign;
        logic [MW-1:0]   a_man;
        logic [EW-1:0]   a_exp;
        logic            a_sign;
    } operands_t;

    typedef struct packed {
        logic [MW-1:0] man;
        logic [EW-1:0] exp;
        logic          sign;
    } fsum_t;

    typedef struct {
        operands_t op;
        logic      has_exp;
        fsum_t     res;
    } row_t;

    localparam int NumRandom = 1550;
    localparam int StallLimit = 20000;
    localparam logic OpAdd = 1'b0;
    localparam logic OpSub = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    fsum_t  sum_queue[$];
    int     failures;
    bit     sending_done;
    bit     hold_long;
    int     rx_cycles;
    int     idle_cycles = 0;

    float23_add_sub_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic fsum_t float_add_sub(operands_t o);
        logic            sx, sy;
        logic [EW-1:0]   ex, ey, d;
        logic [16:0]     mx, my, al;
        logic [17:0]     s;
        int              top, sh;
        fsum_t           r;
        sx = o.a_sign;
        sy = o.b_sign ^ o.b_sub;
        if ({o.a_exp, o.a_man} < {o.b_exp, o.b_man})
        begin
            {sx, sy} = {sy, sx};
            ex = o.b_exp; mx = {1'b0, o.b_man};
            ey = o.a_exp; my = {1'b0, o.a_man};
        end
        else
        begin
            ex = o.a_exp; mx = {1'b0, o.a_man};
            ey = o.b_exp; my = {1'b0, o.b_man};
        end
        mx[16] = (ex != 0);
        my[16] = (ey != 0);
        d = ex - ey;
        al = (d >= 16) ? 17'd0 : (my >> d[3:0]);
        if (sx == sy)
            s = {1'b0, mx} + {1'b0, al};
        else
            s = {1'b0, mx} - {1'b0, al};
        top = -1;
        for (int k = 17; k >= 2; k--)
        begin
            if (s[k] && top < 0)
                top = k;
        end
        sh = (top < 0) ? 31 : 17 - top;
        r.sign = sx;
        r.exp = (int'(ex) < sh) ? '0 : EW'(int'(ex) - sh + 1);
        r.man = MW'((64'(s) >> 1) << sh);
        return r;
    endfunction

    task automatic send_operands(operands_t o);
        s_axis_tdata <= {1'b0, o};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sum_queue.push_back(float_add_sub(o));
        // random gap after a burst
        if ($urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic operands_t rand_operands();
        operands_t o;
        o = operands_t'(47'({$urandom, $urandom}));
        case ($urandom_range(0, 4))
            0: o.b_exp = o.a_exp;
            1: o.b_exp = o.a_exp + EW'($urandom_range(0, 3));
            2:
            begin
                o.b_exp = o.a_exp;
                o.b_man = o.a_man ^ MW'($urandom_range(0, 7));
                o.b_sign = o.a_sign ^ o.b_sub ^ 1'b1;
            end
            default: ;
        endcase
        return o;
    endfunction

    // Directed rows: zero, extremes, equal cancel, wrap, exponent-zero operands
    row_t rows[] = '{
        '{'{OpAdd, 16'h0, 6'd0, 1'b0, 16'h0, 6'd0, 1'b0}, 1'b1, '{16'h0, 6'd0, 1'b0}},
        '{'{OpSub, 16'h1234, 6'd20, 1'b1, 16'h1234, 6'd20, 1'b1}, 1'b1,
          '{16'h0, 6'd0, 1'b1}},
        '{'{OpAdd, 16'h0, 6'd63, 1'b0, 16'h0, 6'd63, 1'b0}, 1'b1, '{16'h0, 6'd0, 1'b0}},
        '{'{OpAdd, 16'hFFFF, 6'd63, 1'b1, 16'hFFFF, 6'd63, 1'b1}, 1'b0, '{0, 0, 0}},
        '{'{OpSub, 16'hFFFF, 6'd63, 1'b0, 16'hFFFF, 6'd0, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpAdd, 16'h0001, 6'd0, 1'b0, 16'h0003, 6'd0, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpSub, 16'h0001, 6'd0, 1'b0, 16'h0003, 6'd0, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpAdd, 16'h8000, 6'd1, 1'b0, 16'h8000, 6'd17, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpAdd, 16'h8000, 6'd1, 1'b0, 16'h8000, 6'd16, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpSub, 16'h0001, 6'd5, 1'b1, 16'h0000, 6'd5, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpAdd, 16'hFFFF, 6'd0, 1'b1, 16'h0000, 6'd40, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpSub, 16'hAAAA, 6'd33, 1'b1, 16'h5555, 6'd30, 1'b0}, 1'b0, '{0, 0, 0}},
        '{'{OpAdd, 16'h0002, 6'd0, 1'b0, 16'h0001, 6'd0, 1'b1}, 1'b0, '{0, 0, 0}}
    };

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sending_done = 1'b0;
        failures = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            if (rows[i].has_exp && float_add_sub(rows[i].op) != rows[i].res)
            begin
                $error("row %0d: table result %h, predictor %h", i, rows[i].res,
                    float_add_sub(rows[i].op));
                failures++;
            end
            send_operands(rows[i].op);
        end
        for (int n = 0; n < NumRandom; n++)
            send_operands(rand_operands());
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: own stall pattern plus one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        hold_long = 1'b0;
        rx_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles == 500 && !hold_long)
            begin
                hold_long = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge clk);
            end
            case ($urandom_range(0, 3))
                0: m_axis_tready <= 1'b0;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        fsum_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = fsum_t'(m_axis_tdata[22:0]);
            if (sum_queue.size() == 0)
            begin
                $error("transfer with no expected sum: %h", got);
                failures++;
            end
            else
            begin
                want = sum_queue.pop_front();
                if (got.sign !== want.sign)
                begin
                    $error("res_sign expected %0h actual %0h", want.sign, got.sign);
                    failures++;
                end
                if (got.exp !== want.exp)
                begin
                    $error("res_exponent expected %0h actual %0h", want.exp, got.exp);
                    failures++;
                end
                if (got.man !== want.man)
                begin
                    $error("res_mantissa expected %0h actual %0h", want.man, got.man);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && idle_cycles > StallLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        wait (sending_done);
        while (sum_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/f23as_pkg.sv
rtl/core/f23as_norm.sv
rtl/core/float23_add_sub_top.sv
bench/float23_add_sub_top_tb.sv
